// File: src/rmcpe_pkg.sv
// Shared constants, types and helpers of the RMC position extractor.
`default_nettype none
package rmcpe_pkg;

  // Header bytes of the position sentence
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_G      = "G";
  localparam logic [7:0] CH_P      = "P";
  localparam logic [7:0] CH_R      = "R";
  localparam logic [7:0] CH_M      = "M";
  localparam logic [7:0] CH_C      = "C";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";

  // header_index value once the whole header has matched
  localparam logic [2:0] HDR_BODY = 3'd7;

  // Body offsets, counted from the byte after the header comma
  localparam logic [5:0] POS_SCALE  = 6'd38;
  localparam logic [5:0] POS_DIVIDE = 6'd39;
  localparam logic [5:0] POS_SUM    = 6'd40;
  localparam logic [5:0] POS_EMIT   = 6'd52;

  // Digit slot kinds
  localparam logic [2:0] SLOT_NONE    = 3'd0;
  localparam logic [2:0] SLOT_LAT_DEG = 3'd1;
  localparam logic [2:0] SLOT_LAT_MIN = 3'd2;
  localparam logic [2:0] SLOT_LON_DEG = 3'd3;
  localparam logic [2:0] SLOT_LON_MIN = 3'd4;

  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;
  localparam int MIN_W     = 20;
  localparam int MIN50_W   = 26;
  localparam int FRAC_W    = 25;
  localparam int LAT_W     = 30;
  localparam int LON_W     = 34;

  localparam logic [23:0] DEG_SCALE = 24'd10000000;
  // floor(x / 3) == (x * RECIP_3) >> RECIP_SHIFT for every x below 2**27
  localparam logic [25:0] RECIP_3     = 26'd44739243;
  localparam int          RECIP_SHIFT = 27;

  typedef struct packed {
    logic scale_en;   // degree multiply and minute * 50
    logic divide_en;  // minute * 50 / 3
    logic sum_en;     // final add
  } rmcpe_ctl_t;

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = CH_DOLLAR;
      3'd1: ch = CH_G;
      3'd2: ch = CH_P;
      3'd3: ch = CH_R;
      3'd4: ch = CH_M;
      3'd5: ch = CH_C;
      3'd6: ch = CH_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] slot_kind(input logic [5:0] pos);
    logic [2:0] kind;
    case (pos)
      6'd16, 6'd17: kind = SLOT_LAT_DEG;
      6'd18, 6'd19, 6'd21, 6'd22, 6'd23, 6'd24: kind = SLOT_LAT_MIN;
      6'd28, 6'd29, 6'd30: kind = SLOT_LON_DEG;
      6'd31, 6'd32, 6'd34, 6'd35, 6'd36, 6'd37: kind = SLOT_LON_MIN;
      default: kind = SLOT_NONE;
    endcase
    return kind;
  endfunction

endpackage
`default_nettype wire

// File: src/rmcpe_field_parser.sv
// Header hunt, body byte counter and decimal digit accumulators.
`default_nettype none
module rmcpe_field_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          beat_en,
  input  wire logic [7:0]                    rx_byte,
  output logic                               at_emit,
  output rmcpe_pkg::rmcpe_ctl_t              ctl,
  output logic [rmcpe_pkg::LAT_DEG_W-1:0]    lat_degree_acc,
  output logic [rmcpe_pkg::MIN_W-1:0]        lat_minute_acc,
  output logic [rmcpe_pkg::LON_DEG_W-1:0]    lon_degree_acc,
  output logic [rmcpe_pkg::MIN_W-1:0]        lon_minute_acc,
  output logic                               bad_digit_seen
);
  import rmcpe_pkg::*;

  logic [2:0]           header_index, header_index_next;
  logic [5:0]           body_position, body_position_next;
  logic [LAT_DEG_W-1:0] lat_degree_acc_next;
  logic [MIN_W-1:0]     lat_minute_acc_next;
  logic [LON_DEG_W-1:0] lon_degree_acc_next;
  logic [MIN_W-1:0]     lon_minute_acc_next;
  logic                 bad_digit_seen_next;
  logic                 in_body;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [2:0]           slot;

  assign in_body  = (header_index == HDR_BODY);
  assign at_emit  = in_body && (body_position >= POS_EMIT);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  // ASCII digits carry their value in the low nibble
  assign digit    = is_digit ? rx_byte[3:0] : 4'd0;
  assign slot     = slot_kind(body_position);

  assign ctl.scale_en  = beat_en && in_body && (body_position == POS_SCALE);
  assign ctl.divide_en = beat_en && in_body && (body_position == POS_DIVIDE);
  assign ctl.sum_en    = beat_en && in_body && (body_position == POS_SUM);

  always_comb begin
    header_index_next   = header_index;
    body_position_next  = body_position;
    lat_degree_acc_next = lat_degree_acc;
    lat_minute_acc_next = lat_minute_acc;
    lon_degree_acc_next = lon_degree_acc;
    lon_minute_acc_next = lon_minute_acc;
    bad_digit_seen_next = bad_digit_seen;
    if (beat_en) begin
      if (!in_body) begin
        // a mismatching byte is dropped, not retried as a dollar
        if (rx_byte == header_char(header_index)) begin
          header_index_next = header_index + 3'd1;
        end else begin
          header_index_next = 3'd0;
        end
        body_position_next = 6'd0;
      end else if (at_emit) begin
        header_index_next   = 3'd0;
        body_position_next  = 6'd0;
        lat_degree_acc_next = '0;
        lat_minute_acc_next = '0;
        lon_degree_acc_next = '0;
        lon_minute_acc_next = '0;
        bad_digit_seen_next = 1'b0;
      end else begin
        if (slot != SLOT_NONE && !is_digit) begin
          bad_digit_seen_next = 1'b1;
        end
        case (slot)
          SLOT_LAT_DEG: lat_degree_acc_next = LAT_DEG_W'({lat_degree_acc, 3'b000}
              + {2'b00, lat_degree_acc, 1'b0} + 10'(digit));
          SLOT_LAT_MIN: lat_minute_acc_next = MIN_W'({lat_minute_acc, 3'b000}
              + {2'b00, lat_minute_acc, 1'b0} + 23'(digit));
          SLOT_LON_DEG: lon_degree_acc_next = LON_DEG_W'({lon_degree_acc, 3'b000}
              + {2'b00, lon_degree_acc, 1'b0} + 13'(digit));
          SLOT_LON_MIN: lon_minute_acc_next = MIN_W'({lon_minute_acc, 3'b000}
              + {2'b00, lon_minute_acc, 1'b0} + 23'(digit));
          default: ;
        endcase
        body_position_next = body_position + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index   <= 3'd0;
      body_position  <= 6'd0;
      lat_degree_acc <= '0;
      lat_minute_acc <= '0;
      lon_degree_acc <= '0;
      lon_minute_acc <= '0;
      bad_digit_seen <= 1'b0;
    end else begin
      header_index   <= header_index_next;
      body_position  <= body_position_next;
      lat_degree_acc <= lat_degree_acc_next;
      lat_minute_acc <= lat_minute_acc_next;
      lon_degree_acc <= lon_degree_acc_next;
      lon_minute_acc <= lon_minute_acc_next;
      bad_digit_seen <= bad_digit_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (beat_en && at_emit) |=> (header_index == 3'd0 && body_position == 6'd0
                              && !bad_digit_seen))
    else $error("state not cleared after emit beat");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    body_position <= POS_EMIT)
    else $error("body position ran past emit offset");

  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (header_index != HDR_BODY) |-> (body_position == 6'd0))
    else $error("body position nonzero while hunting header");
`endif

endmodule
`default_nettype wire

// File: src/rmcpe_scaler.sv
// Converts the digit accumulators to 1e-7 degree units over three body beats.
`default_nettype none
module rmcpe_scaler (
  input  wire logic                              clk,
  input  wire rmcpe_pkg::rmcpe_ctl_t             ctl,
  input  wire logic [rmcpe_pkg::LAT_DEG_W-1:0]   lat_degree_acc,
  input  wire logic [rmcpe_pkg::MIN_W-1:0]       lat_minute_acc,
  input  wire logic [rmcpe_pkg::LON_DEG_W-1:0]   lon_degree_acc,
  input  wire logic [rmcpe_pkg::MIN_W-1:0]       lon_minute_acc,
  output logic [rmcpe_pkg::LAT_W-1:0]            lat_sum,
  output logic [rmcpe_pkg::LON_W-1:0]            lon_sum
);
  import rmcpe_pkg::*;

  localparam int LAT_SCALED_W = 31;
  localparam int PROD_W       = MIN50_W + 26;

  logic [LAT_SCALED_W-1:0] lat_deg_scaled;
  logic [LON_W-1:0]        lon_deg_scaled;
  logic [MIN50_W-1:0]      lat_min50, lon_min50;
  logic [FRAC_W-1:0]       lat_frac, lon_frac;
  logic [PROD_W-1:0]       lat_prod, lon_prod;

  // x*50 = x*32 + x*16 + x*2
  function automatic logic [MIN50_W-1:0] times50(input logic [MIN_W-1:0] x);
    return {1'b0, x, 5'b00000} + {2'b00, x, 4'b0000} + {5'b00000, x, 1'b0};
  endfunction

  assign lat_prod = PROD_W'(lat_min50) * PROD_W'(RECIP_3);
  assign lon_prod = PROD_W'(lon_min50) * PROD_W'(RECIP_3);

  always_ff @(posedge clk) begin
    if (ctl.scale_en) begin
      lat_deg_scaled <= LAT_SCALED_W'(lat_degree_acc) * LAT_SCALED_W'(DEG_SCALE);
      lon_deg_scaled <= LON_W'(lon_degree_acc) * LON_W'(DEG_SCALE);
      lat_min50      <= times50(lat_minute_acc);
      lon_min50      <= times50(lon_minute_acc);
    end
    if (ctl.divide_en) begin
      lat_frac <= lat_prod[RECIP_SHIFT +: FRAC_W];
      lon_frac <= lon_prod[RECIP_SHIFT +: FRAC_W];
    end
    if (ctl.sum_en) begin
      lat_sum <= LAT_W'(lat_deg_scaled + LAT_SCALED_W'(lat_frac));
      lon_sum <= lon_deg_scaled + LON_W'(lon_frac);
    end
  end

endmodule
`default_nettype wire

// File: src/rmc_position_extractor.sv
// Top level of the RMC position extractor: input beat register, parser, scaler, result register.
//
// Takes one received byte per beat and accepts a byte every cycle unless intake stalls. A byte
// waits in the input register and is then applied to the parser state; a position result lands
// in the output register on that same edge. The sentence is "$GPRMC," followed by body bytes;
// the result is issued on body byte 52, whose value is ignored. Degree scaling and the divide by
// three run on body bytes 38 to 40, so they add nothing after the emit byte. Intake stalls only
// when a result byte arrives while the previous result is still held.
`default_nettype none
module rmc_position_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [29:0] latitude_e7, [63:30] longitude_e7
  output logic             m_axis_tuser    // [0] digit_error
);
  import rmcpe_pkg::*;

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 out_free;
  logic                 advance;
  logic                 at_emit;
  rmcpe_ctl_t           ctl;
  logic [LAT_DEG_W-1:0] lat_degree_acc;
  logic [MIN_W-1:0]     lat_minute_acc;
  logic [LON_DEG_W-1:0] lon_degree_acc;
  logic [MIN_W-1:0]     lon_minute_acc;
  logic                 bad_digit_seen;
  logic [LAT_W-1:0]     lat_sum;
  logic [LON_W-1:0]     lon_sum;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = s1_valid && (!at_emit || out_free);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_byte <= s_axis_tdata;
    end
  end

  rmcpe_field_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .beat_en        (advance),
    .rx_byte        (s1_byte),
    .at_emit        (at_emit),
    .ctl            (ctl),
    .lat_degree_acc (lat_degree_acc),
    .lat_minute_acc (lat_minute_acc),
    .lon_degree_acc (lon_degree_acc),
    .lon_minute_acc (lon_minute_acc),
    .bad_digit_seen (bad_digit_seen)
  );

  rmcpe_scaler u_scaler (
    .clk            (clk),
    .ctl            (ctl),
    .lat_degree_acc (lat_degree_acc),
    .lat_minute_acc (lat_minute_acc),
    .lon_degree_acc (lon_degree_acc),
    .lon_minute_acc (lon_minute_acc),
    .lat_sum        (lat_sum),
    .lon_sum        (lon_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && at_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && at_emit) begin
      m_axis_tdata <= {lon_sum, lat_sum};
      m_axis_tuser <= bad_digit_seen;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance && at_emit))
    else $error("result appeared without an emit beat");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && at_emit && m_axis_tvalid && !m_axis_tready))
    else $error("intake stalled without a held result");
`endif

endmodule
`default_nettype wire

// File: test/rmc_position_extractor_tb.sv
`timescale 1ns / 100ps
// Testbench for rmc_position_extractor: directed sentences and random byte streams.
module rmc_position_extractor_tb;
  import rmcpe_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_STALL    = 400;
  localparam int NUM_DIGITS    = 17;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic             err;
  } pos_fix_t;

  typedef enum logic {ROW_SENTENCE, ROW_RAW} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [8*NUM_DIGITS-1:0] text;   // digits, or raw bytes, first char leftmost
    int                    len;
    logic [7:0]            fill;
    logic [7:0]            emit;
    bit                    typed;
    logic [LAT_W-1:0]      lat;
    logic [LON_W-1:0]      lon;
    logic                  err;
  } dir_row_t;

  // Digit text order: lat deg (2), lat min (6), lon deg (3), lon min (6)
  dir_row_t dir_rows [13] = '{
    '{ROW_SENTENCE, "00000000000000000", 17, ",",   "*",   1, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "99999999999999999", 17, 8'hFF, 8'h00, 1,
      30'd1006666650, 34'd10006666650, 1'b0},
    '{ROW_SENTENCE, "48070380011310000", 17, "A",   "$",   0, 30'd0, 34'd0, 1'b0},
    '{ROW_RAW,      "$$GPRMC,",          8,  8'h00, 8'h00, 0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "12345678901234567", 17, 8'h00, 8'hFF, 0, 30'd0, 34'd0, 1'b0},
    '{ROW_RAW,      "$GPRMC$",           7,  8'h00, 8'h00, 0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "                 ", 17, ",",   "*",   1, 30'd0, 34'd0, 1'b1},
    '{ROW_RAW,      "GPRMC,$",           7,  8'h00, 8'h00, 0, 30'd0, 34'd0, 1'b0},
    // lost: the pending dollar makes this sentence's own dollar mismatch
    '{ROW_SENTENCE, "55555555555555555", 17, ",",   "$",   0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "/:/:/:/:/:/:/:/:/", 17, ",",   "*",   0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "90000000180000000", 17, "N",   "*",   0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "00999999000999999", 17, 8'h7F, 8'h80, 0, 30'd0, 34'd0, 1'b0},
    '{ROW_SENTENCE, "99000000999000000", 17, 8'h55, 8'hAA, 0, 30'd0, 34'd0, 1'b0}
  };

  logic [7:0] hdr_bytes [7] = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C, CH_COMMA};

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  // parser state mirror
  logic [2:0]           hdr_idx;
  logic [5:0]           body_cnt;
  logic [LAT_DEG_W-1:0] lat_deg;
  logic [MIN_W-1:0]     lat_min;
  logic [LON_DEG_W-1:0] lon_deg;
  logic [MIN_W-1:0]     lon_min;
  logic                 bad_seen;

  pos_fix_t fix_q [$];

  int send_idle_pct = 13;
  int recv_idle_pct = 60;
  int stall_left    = 0;
  int bytes_sent    = 0;
  int fixes_pred    = 0;
  int errs_pred     = 0;
  int fixes_seen    = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;

  rmc_position_extractor i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Index into the 17-digit text for a body offset, -1 where the byte is not a digit
  function automatic int digit_slot(input logic [5:0] pos);
    if (pos >= 6'd16 && pos <= 6'd19) return pos - 16;
    if (pos >= 6'd21 && pos <= 6'd24) return pos - 17;
    if (pos >= 6'd28 && pos <= 6'd32) return pos - 20;
    if (pos >= 6'd34 && pos <= 6'd37) return pos - 21;
    return -1;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b >= CH_ZERO && b <= CH_NINE) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic clear_parser();
    hdr_idx  = '0;
    body_cnt = '0;
    lat_deg  = '0;
    lat_min  = '0;
    lon_deg  = '0;
    lon_min  = '0;
    bad_seen = 1'b0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int         idx;
    logic [3:0] d;
    pos_fix_t   fix;
    if (hdr_idx != HDR_BODY) begin
      // a mismatching byte is dropped, not retried as a dollar
      if (b == hdr_bytes[hdr_idx]) hdr_idx = hdr_idx + 3'd1;
      else hdr_idx = '0;
      body_cnt = '0;
    end else if (body_cnt >= POS_EMIT) begin
      fix.lat = LAT_W'(64'(lat_deg) * 64'd10000000 + 64'(lat_min) * 64'd50 / 64'd3);
      fix.lon = LON_W'(64'(lon_deg) * 64'd10000000 + 64'(lon_min) * 64'd50 / 64'd3);
      fix.err = bad_seen;
      fix_q.push_back(fix);
      fixes_pred++;
      if (bad_seen) errs_pred++;
      clear_parser();
    end else begin
      idx = digit_slot(body_cnt);
      if (idx >= 0) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          d = 4'(b - CH_ZERO);
        end else begin
          d = 4'd0;
          bad_seen = 1'b1;
        end
        if (idx < 2) lat_deg = LAT_DEG_W'(lat_deg * 10 + d);
        else if (idx < 8) lat_min = MIN_W'(lat_min * 10 + d);
        else if (idx < 11) lon_deg = LON_DEG_W'(lon_deg * 10 + d);
        else lon_min = MIN_W'(lon_min * 10 + d);
      end
      body_cnt = body_cnt + 6'd1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_sentence(input logic [7:0] digs [NUM_DIGITS], input bit rand_fill,
                               input logic [7:0] fill_ch, input logic [7:0] emit_ch);
    int         idx;
    logic [7:0] ch;
    foreach (hdr_bytes[i]) send_byte(hdr_bytes[i]);
    for (int p = 0; p < POS_EMIT; p++) begin
      idx = digit_slot(6'(p));
      if (idx >= 0) ch = digs[idx];
      else if (p == 20 || p == 33) ch = ".";
      else if (rand_fill) ch = 8'($urandom_range(255));
      else ch = fill_ch;
      send_byte(ch);
    end
    send_byte(emit_ch);
  endtask

  // Hold the input low until every predicted fix has come out
  task automatic drain_fixes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (fix_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [7:0] digs [NUM_DIGITS];
    int         n0;
    for (int r = 0; r < $size(dir_rows); r++) begin
      if (dir_rows[r].kind == ROW_RAW) begin
        for (int i = 0; i < dir_rows[r].len; i++)
          send_byte(dir_rows[r].text[8*(dir_rows[r].len-1-i) +: 8]);
      end else begin
        for (int i = 0; i < NUM_DIGITS; i++)
          digs[i] = dir_rows[r].text[8*(NUM_DIGITS-1-i) +: 8];
        n0 = fixes_pred;
        send_sentence(digs, 1'b0, dir_rows[r].fill, dir_rows[r].emit);
        if (dir_rows[r].typed && fixes_pred != n0)
          fix_q[fix_q.size()-1] = '{dir_rows[r].lat, dir_rows[r].lon, dir_rows[r].err};
      end
    end
  endtask

  task automatic run_random(input int min_bytes, input int min_fixes);
    logic [7:0] digs [NUM_DIGITS];
    int         b0;
    int         f0;
    int         pick;
    int         plen;
    b0 = bytes_sent;
    f0 = fixes_pred;
    while (bytes_sent - b0 < min_bytes || fixes_pred - f0 < min_fixes) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        // full sentence, random digits, at times all nines or with up to three non-digit slots
        if ($urandom_range(7) == 0) foreach (digs[i]) digs[i] = CH_NINE;
        else foreach (digs[i]) digs[i] = 8'(CH_ZERO + $urandom_range(9));
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(3, 1)) digs[$urandom_range(NUM_DIGITS-1)] = non_digit();
        send_sentence(digs, 1'($urandom_range(1)), ",", 8'($urandom_range(255)));
      end else if (pick < 86) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick < 95) begin
        // header cut short by an arbitrary byte
        plen = $urandom_range(6, 1);
        for (int i = 0; i < plen; i++) send_byte(hdr_bytes[i]);
        send_byte(8'($urandom_range(255)));
      end else begin
        foreach (hdr_bytes[i]) send_byte(hdr_bytes[i]);
        repeat (POS_EMIT + 1) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic check_fix(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                           input logic err);
    pos_fix_t want;
    if (fix_q.size() == 0) begin
      $display("%0t: unexpected result lat=%0d lon=%0d err=%0b", $time, lat, lon, err);
      fail_cnt++;
    end else begin
      want = fix_q.pop_front();
      fixes_seen++;
      if (lat !== want.lat) begin
        $display("%0t: latitude_e7 mismatch: expected %0d, got %0d", $time, want.lat, lat);
        fail_cnt++;
      end
      if (lon !== want.lon) begin
        $display("%0t: longitude_e7 mismatch: expected %0d, got %0d", $time, want.lon, lon);
        fail_cnt++;
      end
      if (err !== want.err) begin
        $display("%0t: digit_error mismatch: expected %0b, got %0b", $time, want.err, err);
        fail_cnt++;
      end
    end
  endtask

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      check_fix(m_axis_tdata[LAT_W-1:0], m_axis_tdata[LAT_W +: LON_W], m_axis_tuser);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, fix_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 60;
    run_directed();
    run_random(420, 6);
    drain_fixes();

    send_idle_pct = 60;
    recv_idle_pct = 13;
    run_random(420, 6);
    drain_fixes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = LONG_STALL;  // output blocked while input keeps coming
    run_random(420, 6);

    drain_fixes();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; %0d position results checked, %0d with digit errors.",
             bytes_sent, fixes_seen, errs_pred);
    $display("Covered header mismatches, bad digit slots, extremes, three idle mixes, long stall.");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: rmc_position_extractor.f
src/rmcpe_pkg.sv
src/rmcpe_field_parser.sv
src/rmcpe_scaler.sv
src/rmc_position_extractor.sv
test/rmc_position_extractor_tb.sv
